// File: hdl/dc2cal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Calendar conversion package
// Payload types, reciprocal constants and the cumulative month table used by
// the day count to calendar time converter.
// ----------------------------------------------------------------------------
package dc2cal_pkg;

   // Default last year of the calendar range.
   localparam int unsigned MAX_YEAR_DEFAULT = 9999;

   // Width of the year number and of the year search.
   localparam int unsigned YEAR_W = 14;

   // Scaled reciprocals: (x * DIV125_RECIP) >> 31 is x / 125 for x below 2^24,
   // (x * DIV15_RECIP) >> 19 is x / 15 for x below 2^16 and
   // (x * DIV25_RECIP) >> 15 is x / 25 for x below 4096.
   localparam logic [24:0] DIV125_RECIP = 25'd17179870;
   localparam logic [24:0] DIV15_RECIP  = 25'd34953;
   localparam logic [24:0] DIV25_RECIP  = 25'd1311;

   // Day of year before the first of each month, common and leap years.
   localparam logic [8:0] MONTH_START [2][12] = '{
      '{9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334},
      '{9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335}
   };

   typedef struct packed {
      logic [21:0] day_count;
      logic [26:0] msec_of_day;
   } req_data_type;

   typedef struct packed {
      logic [13:0] year_number;
      logic [8:0]  day_of_year;
      logic [3:0]  month_number;
      logic [4:0]  day_of_month;
      logic [4:0]  hour_of_day;
      logic [5:0]  minute_of_hour;
      logic [5:0]  second_of_minute;
   } rsp_data_type;

   // Day count of 1 January of a year; evaluated at elaboration only.
   function automatic longint unsigned year_start_days(input longint unsigned y);
      longint unsigned n;
      if (y == 0) begin
         return 0;
      end
      n = y - 1;
      return 365 * y + n / 4 - n / 100 + n / 400 + 1;
   endfunction

endpackage

// File: hdl/day_count_to_calendar_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Day count to calendar time converter
// Turns a proleptic Gregorian day count and milliseconds since midnight into
// year, day of year, month, day of month, hour, minute and second.
// ----------------------------------------------------------------------------
//
//   Channel  | Dir | Ports                          | Contents
//   ---------+-----+--------------------------------+---------------------------
//   request  | in  | req_valid, req_ready, req_data | day count, ms of day
//   response | out | rsp_valid, rsp_ready, rsp_data | date and time of day
//
// The converter handles one request at a time: req_ready is high only in the
// idle state, which is entered again in the cycle that rsp_valid rises.
// The year search runs over the 14 bits of the year, a multiply step and then a
// compare step for each bit, on the single shared multiplier.
// The time-of-day divisions come first: seconds, minutes and hours on the same
// multiplier, then a step that finishes the minute and the hour.
// Reset is synchronous and clears the sequencer and the response valid.
// A stalled response is held in its register while the next request is taken.
//
module day_count_to_calendar_time #(
   parameter int unsigned MAX_YEAR = dc2cal_pkg::MAX_YEAR_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  dc2cal_pkg::req_data_type req_data,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output dc2cal_pkg::rsp_data_type rsp_data
);

   // Last day of year MAX_YEAR; larger day counts saturate to it.
   localparam logic [25:0] DAY_LIMIT =
      26'(dc2cal_pkg::year_start_days(64'(MAX_YEAR) + 64'd1) - 64'd1);

   typedef enum logic [10:0] {
      ST_IDLE   = 11'b000_0000_0001,
      ST_T_SEC  = 11'b000_0000_0010,
      ST_T_MIN  = 11'b000_0000_0100,
      ST_T_HR   = 11'b000_0000_1000,
      ST_T_END  = 11'b000_0001_0000,
      ST_Y_MUL  = 11'b000_0010_0000,
      ST_Y_CMP  = 11'b000_0100_0000,
      ST_L_MUL  = 11'b000_1000_0000,
      ST_L_CHK  = 11'b001_0000_0000,
      ST_MONTH  = 11'b010_0000_0000,
      ST_FINISH = 11'b100_0000_0000
   } state_type;

   state_type                state_ff, state_in;
   logic [21:0]              days_ff, days_in;
   logic [26:0]              ms_ff, ms_in;
   logic [48:0]              prod_ff, prod_in;
   logic [17:0]              sec_tot_ff, sec_tot_in;
   logic [11:0]              min_tot_ff, min_tot_in;
   logic [5:0]               second_ff, second_in;
   logic [5:0]               minute_ff, minute_in;
   logic [4:0]               hour_ff, hour_in;
   logic [13:0]              year_ff, year_in;
   logic [22:0]              ystart_ff, ystart_in;
   logic [3:0]               bit_ff, bit_in;
   logic                     leap_ff, leap_in;
   logic [8:0]               yday_ff, yday_in;
   logic [3:0]               mon_ff, mon_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   dc2cal_pkg::rsp_data_type rsp_data_ff, rsp_data_in;

   logic [23:0] mul_a;
   logic [24:0] mul_b;
   logic [13:0] trial;
   logic [13:0] trial_m1;
   logic [11:0] trial_q4;
   logic [7:0]  cent_q;
   logic [22:0] trial_start;
   logic [17:0] sec_tot_w;
   logic [11:0] min_tot_w;
   logic [5:0]  hr_w;
   logic        hundred;
   logic [3:0]  mon_cnt;
   logic        out_free;

   // Year search candidate and its first day: 365 t + n/4 - n/100 + n/400 + 1,
   // with n = t - 1 and n/100 taken from the registered product.
   assign trial       = year_ff | (14'd1 << bit_ff);
   assign trial_m1    = trial - 14'd1;
   assign trial_q4    = trial_m1[13:2];
   assign cent_q      = prod_ff[22:15];
   assign trial_start = 23'(trial) * 23'd365 + 23'(trial_q4) - 23'(cent_q)
                        + 23'(cent_q[7:2]) + 23'd1;

   // Quotients read out of the shared multiplier product.
   assign sec_tot_w = prod_ff[48:31];
   assign min_tot_w = prod_ff[30:19];
   assign hr_w      = prod_ff[24:19];

   // The year is a multiple of 100 when its quotient by 100 multiplies back.
   assign hundred = (14'(cent_q) * 14'd100) == year_ff;

   assign out_free = !rsp_valid_ff || rsp_ready;

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_T_SEC: begin
            mul_a = ms_ff[26:3];
            mul_b = dc2cal_pkg::DIV125_RECIP;
         end
         ST_T_MIN: begin
            mul_a = 24'(sec_tot_w[17:2]);
            mul_b = dc2cal_pkg::DIV15_RECIP;
         end
         ST_T_HR: begin
            mul_a = 24'(min_tot_w[11:2]);
            mul_b = dc2cal_pkg::DIV15_RECIP;
         end
         ST_Y_MUL: begin
            mul_a = 24'(trial_q4);
            mul_b = dc2cal_pkg::DIV25_RECIP;
         end
         ST_L_MUL: begin
            mul_a = 24'(year_ff[13:2]);
            mul_b = dc2cal_pkg::DIV25_RECIP;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = 49'(mul_a) * 49'(mul_b);

   // Month index: the number of later month starts that lie on or before the day.
   always_comb begin
      mon_cnt = '0;
      for (int i = 1; i < 12; i++) begin
         if (dc2cal_pkg::MONTH_START[leap_ff][i] < yday_ff) begin
            mon_cnt = mon_cnt + 4'd1;
         end
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in     = state_ff;
      days_in      = days_ff;
      ms_in        = ms_ff;
      sec_tot_in   = sec_tot_ff;
      min_tot_in   = min_tot_ff;
      second_in    = second_ff;
      minute_in    = minute_ff;
      hour_in      = hour_ff;
      year_in      = year_ff;
      ystart_in    = ystart_ff;
      bit_in       = bit_ff;
      leap_in      = leap_ff;
      yday_in      = yday_ff;
      mon_in       = mon_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if ({4'd0, req_data.day_count} > DAY_LIMIT) begin
                  days_in = DAY_LIMIT[21:0];
               end else begin
                  days_in = req_data.day_count;
               end
               ms_in    = req_data.msec_of_day;
               state_in = ST_T_SEC;
            end
         end
         ST_T_SEC: begin
            state_in = ST_T_MIN;
         end
         ST_T_MIN: begin
            sec_tot_in = sec_tot_w;
            state_in   = ST_T_HR;
         end
         ST_T_HR: begin
            min_tot_in = min_tot_w;
            second_in  = 6'(sec_tot_ff - 18'(min_tot_w) * 18'd60);
            state_in   = ST_T_END;
         end
         ST_T_END: begin
            minute_in = 6'(min_tot_ff - 12'(hr_w) * 12'd60);
            if (hr_w >= 6'd24) begin
               hour_in = 5'(hr_w - 6'd24);
            end else begin
               hour_in = hr_w[4:0];
            end
            year_in   = '0;
            ystart_in = '0;
            bit_in    = 4'(dc2cal_pkg::YEAR_W - 1);
            state_in  = ST_Y_MUL;
         end
         ST_Y_MUL: begin
            state_in = ST_Y_CMP;
         end
         ST_Y_CMP: begin
            // Keep the candidate bit when its year starts on or before the day.
            if (trial_start <= 23'(days_ff)) begin
               year_in   = trial;
               ystart_in = trial_start;
            end
            if (bit_ff == 4'd0) begin
               state_in = ST_L_MUL;
            end else begin
               bit_in   = bit_ff - 4'd1;
               state_in = ST_Y_MUL;
            end
         end
         ST_L_MUL: begin
            state_in = ST_L_CHK;
         end
         ST_L_CHK: begin
            leap_in  = (year_ff[1:0] == 2'd0) && (!hundred || (cent_q[1:0] == 2'd0));
            yday_in  = 9'(23'(days_ff) - ystart_ff + 23'd1);
            state_in = ST_MONTH;
         end
         ST_MONTH: begin
            mon_in   = mon_cnt;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in.year_number      = year_ff;
               rsp_data_in.day_of_year      = yday_ff;
               rsp_data_in.month_number     = mon_ff + 4'd1;
               rsp_data_in.day_of_month     =
                  5'(yday_ff - dc2cal_pkg::MONTH_START[leap_ff][mon_ff]);
               rsp_data_in.hour_of_day      = hour_ff;
               rsp_data_in.minute_of_hour   = minute_ff;
               rsp_data_in.second_of_minute = second_ff;
               rsp_valid_in                 = 1'b1;
               state_in                     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      days_ff     <= days_in;
      ms_ff       <= ms_in;
      prod_ff     <= prod_in;
      sec_tot_ff  <= sec_tot_in;
      min_tot_ff  <= min_tot_in;
      second_ff   <= second_in;
      minute_ff   <= minute_in;
      hour_ff     <= hour_in;
      year_ff     <= year_in;
      ystart_ff   <= ystart_in;
      bit_ff      <= bit_in;
      leap_ff     <= leap_in;
      yday_ff     <= yday_in;
      mon_ff      <= mon_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new response is only ever loaded from the final sequencer step.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FINISH))
      else $error("response raised outside the final step");

   // The year search never moves past its top bit.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_Y_CMP) |-> (bit_ff < 4'(dc2cal_pkg::YEAR_W)))
      else $error("year search bit out of range");

   // Month lies in 1 to 12 and day of month is at least 1.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.month_number >= 4'd1) && (rsp_data_ff.month_number <= 4'd12)
                       && (rsp_data_ff.day_of_month >= 5'd1))
      else $error("month or day of month out of range");

   // The saturated day count never yields a year past the last one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (32'(rsp_data_ff.year_number) <= MAX_YEAR))
      else $error("year beyond the configured range");

   // The day of year is one-based and at most 366.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.day_of_year >= 9'd1) && (rsp_data_ff.day_of_year <= 9'd366))
      else $error("day of year out of range");

endmodule
